FILE: rtl/boxds_pkg.sv
`timescale 1ns / 1ps
// Shared package for the box-average downscaler: sizes, register indexes,
// controller states and the command/status bundles. No dependencies.
package boxds_pkg;

   // Sizing
   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_FACTOR  = 16;
   localparam int PIX_W       = 16;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WIDTH_W     = COL_W + 1;
   localparam int HEIGHT_W    = 13;
   localparam int FACTOR_W    = $clog2(MAX_FACTOR) + 1;
   localparam int SUB_W       = $clog2(MAX_FACTOR);
   localparam int RUN_W       = PIX_W + SUB_W;
   localparam int SUM_W       = RUN_W + SUB_W;
   localparam int DIVIDEND_W  = SUM_W + 2;
   localparam int DIVISOR_W   = 2 * SUB_W + 1;
   localparam int DIV_STEPS   = PIX_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 13;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FACTOR_X     = 3'd0,
      REG_FACTOR_Y     = 3'd1,
      REG_IMAGE_WIDTH  = 3'd2,
      REG_IMAGE_HEIGHT = 3'd3,
      REG_BYTE_MODE    = 3'd4
   } csr_index_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACC,
      ST_DIV,
      ST_OUT
   } ctrl_state_type;

   // Controller -> datapath
   typedef struct packed {
      logic accept;
      logic col_write;
      logic div_start;
      logic load_out;
   } dp_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic block_end;
      logic emit;
      logic div_done;
      logic slot_free;
   } dp_status_type;

endpackage

FILE: rtl/box_average_image_downscaler.sv
`timescale 1ns / 1ps
// Top level of the box-average downscaler: controller plus datapath.
// Depends on boxds_pkg, boxds_ctrl, boxds_datapath.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | req_pixel_in[15:0]
//  rsp     | out       | rsp_valid/stall    | rsp_pixel_out[15:0], rsp_row_end, rsp_slice_end
//  csr     | in        | csr_valid/ready    | csr_index[2:0], csr_wdata[12:0]
//
// A pixel inside a block run is taken in ST_IDLE alone; one that closes a block run
// also passes through ST_ACC (column store read, then add and write back).
// A pixel that completes a block then waits for the 16-step restoring divider,
// plus any wait for the output register to empty.
// Reset is synchronous; the column store is not cleared, since the first line
// of each block row starts its column sums from zero. csr_ready is always high.
// An item is accepted while a finished result still sits in the output register.
module box_average_image_downscaler (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [boxds_pkg::PIX_W-1:0]       req_pixel_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [boxds_pkg::PIX_W-1:0]       rsp_pixel_out,
   output logic                              rsp_row_end,
   output logic                              rsp_slice_end,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [boxds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [boxds_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import boxds_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Register writes are always accepted
   assign csr_ready = 1'b1;

   boxds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   boxds_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_pixel_in  (req_pixel_in),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_row_end   (rsp_row_end),
      .rsp_slice_end (rsp_slice_end)
   );

endmodule

FILE: rtl/boxds_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the block average.
// Depends on boxds_pkg. The quotient is known to fit in PIX_W bits.
module boxds_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [boxds_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [boxds_pkg::DIVISOR_W-1:0]   divisor,
   output logic                              done,
   output logic [boxds_pkg::PIX_W-1:0]       quotient
);
   import boxds_pkg::*;

   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [PIX_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 fits;

   // Shift in the next dividend bit and try a subtract
   always_comb begin
      trial = {rem_ff, quo_ff[PIX_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      fits  = (trial >= {1'b0, dsr_ff});
   end

   // Next-state of the iteration
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         // upper dividend bits are below the divisor, so they seed the remainder
         rem_in  = dividend[PIX_W +: DIVISOR_W];
         quo_in  = dividend[PIX_W-1:0];
         dsr_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in  = {quo_ff[PIX_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Operands
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/boxds_datapath.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, raster counters, row run sum, column
// sum store, divider and output register. Depends on boxds_pkg, boxds_div.
module boxds_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  boxds_pkg::dp_cmd_type             cmd,
   output boxds_pkg::dp_status_type          status,
   input  logic [boxds_pkg::PIX_W-1:0]       req_pixel_in,
   input  logic                              csr_valid,
   input  logic [boxds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [boxds_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [boxds_pkg::PIX_W-1:0]       rsp_pixel_out,
   output logic                              rsp_row_end,
   output logic                              rsp_slice_end
);
   import boxds_pkg::*;

   // Configuration (held as effective, clamped values)
   logic [FACTOR_W-1:0]  fx_ff, fx_in;
   logic [FACTOR_W-1:0]  fy_ff, fy_in;
   logic [WIDTH_W-1:0]   width_ff, width_in;
   logic [HEIGHT_W-1:0]  height_ff, height_in;
   logic                 byte_mode_ff, byte_mode_in;
   logic                 restart;
   logic [FACTOR_W-1:0]  wr_factor;
   logic [WIDTH_W-1:0]   wr_width;
   logic [HEIGHT_W-1:0]  wr_height;

   // Raster position
   logic [COL_W-1:0]     x_ff, x_in;
   logic [SUB_W-1:0]     xsub_ff, xsub_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [HEIGHT_W-1:0]  y_ff, y_in;
   logic [SUB_W-1:0]     ysub_ff, ysub_in;
   logic [RUN_W-1:0]     run_ff, run_in;

   // Item decode
   logic [PIX_W-1:0]     pix;
   logic [RUN_W-1:0]     run_total;
   logic                 block_end;
   logic                 row_last;
   logic                 slice_last;
   logic                 line_last;
   logic                 last_col;
   logic                 last_row;

   // Column store and block-end hold
   logic [SUM_W-1:0]     col_mem [MAX_WIDTH];
   logic [SUM_W-1:0]     rd_ff;
   logic [RUN_W-1:0]     hold_ff;
   logic [COL_W-1:0]     addr_ff;
   logic                 first_line_ff;
   logic                 emit_ff;
   logic                 last_col_ff;
   logic                 last_row_ff;
   logic [SUM_W-1:0]     total;

   // Divider
   logic [DIVIDEND_W-1:0]   dividend;
   logic [2*FACTOR_W-1:0]   area;
   logic                    div_done;
   logic [PIX_W-1:0]        quotient;

   // Output register
   logic                 out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]     out_pixel_ff;
   logic                 out_row_end_ff;
   logic                 out_slice_end_ff;

   // Clamp write data to legal ranges (zero acts as one)
   always_comb begin
      wr_factor = csr_wdata[FACTOR_W-1:0];
      if (wr_factor == '0) begin
         wr_factor = FACTOR_W'(1);
      end else if (wr_factor > FACTOR_W'(MAX_FACTOR)) begin
         wr_factor = FACTOR_W'(MAX_FACTOR);
      end
      wr_width = csr_wdata[WIDTH_W-1:0];
      if (wr_width == '0) begin
         wr_width = WIDTH_W'(1);
      end else if (wr_width > WIDTH_W'(MAX_WIDTH)) begin
         wr_width = WIDTH_W'(MAX_WIDTH);
      end
      wr_height = csr_wdata[HEIGHT_W-1:0];
      if (wr_height == '0) begin
         wr_height = HEIGHT_W'(1);
      end
   end

   // Register writes; any known index restarts the slice
   always_comb begin
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      byte_mode_in = byte_mode_ff;
      restart      = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            REG_FACTOR_X: begin
               fx_in   = wr_factor;
               restart = 1'b1;
            end
            REG_FACTOR_Y: begin
               fy_in   = wr_factor;
               restart = 1'b1;
            end
            REG_IMAGE_WIDTH: begin
               width_in = wr_width;
               restart  = 1'b1;
            end
            REG_IMAGE_HEIGHT: begin
               height_in = wr_height;
               restart   = 1'b1;
            end
            REG_BYTE_MODE: begin
               byte_mode_in = csr_wdata[0];
               restart      = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fx_ff        <= FACTOR_W'(1);
         fy_ff        <= FACTOR_W'(1);
         width_ff     <= WIDTH_W'(MAX_WIDTH);
         height_ff    <= HEIGHT_W'(4096);
         byte_mode_ff <= 1'b0;
      end else begin
         fx_ff        <= fx_in;
         fy_ff        <= fy_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         byte_mode_ff <= byte_mode_in;
      end
   end

   // Decode the incoming item against the current position
   always_comb begin
      pix        = byte_mode_ff ? {(PIX_W/2)'(0), req_pixel_in[PIX_W/2-1:0]} : req_pixel_in;
      run_total  = run_ff + RUN_W'(pix);
      block_end  = ({1'b0, xsub_ff} == (fx_ff - FACTOR_W'(1)));
      line_last  = ({1'b0, ysub_ff} == (fy_ff - FACTOR_W'(1)));
      row_last   = (({1'b0, x_ff} + WIDTH_W'(1)) == width_ff);
      slice_last = ((y_ff + HEIGHT_W'(1)) == height_ff);
      // no whole block fits after this one
      last_col   = (({2'b0, x_ff} + (WIDTH_W+1)'(1) + (WIDTH_W+1)'(fx_ff))
                    > {1'b0, width_ff});
      last_row   = (({1'b0, y_ff} + (HEIGHT_W+1)'(1) + (HEIGHT_W+1)'(fy_ff))
                    > {1'b0, height_ff});
   end

   // Position and row run update
   always_comb begin
      x_in    = x_ff;
      xsub_in = xsub_ff;
      col_in  = col_ff;
      y_in    = y_ff;
      ysub_in = ysub_ff;
      run_in  = run_ff;
      if (restart) begin
         x_in    = '0;
         xsub_in = '0;
         col_in  = '0;
         y_in    = '0;
         ysub_in = '0;
         run_in  = '0;
      end else if (cmd.accept) begin
         if (block_end) begin
            run_in  = '0;
            xsub_in = '0;
            col_in  = col_ff + COL_W'(1);
         end else begin
            run_in  = run_total;
            xsub_in = xsub_ff + SUB_W'(1);
         end
         if (row_last) begin
            // partial trailing block is dropped with the run
            x_in    = '0;
            xsub_in = '0;
            col_in  = '0;
            run_in  = '0;
            if (slice_last) begin
               y_in    = '0;
               ysub_in = '0;
            end else begin
               y_in    = y_ff + HEIGHT_W'(1);
               ysub_in = line_last ? '0 : (ysub_ff + SUB_W'(1));
            end
         end else begin
            x_in = x_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff    <= '0;
         xsub_ff <= '0;
         col_ff  <= '0;
         y_ff    <= '0;
         ysub_ff <= '0;
         run_ff  <= '0;
      end else begin
         x_ff    <= x_in;
         xsub_ff <= xsub_in;
         col_ff  <= col_in;
         y_ff    <= y_in;
         ysub_ff <= ysub_in;
         run_ff  <= run_in;
      end
   end

   // Capture a finished run and fetch its column entry
   always_ff @(posedge clock) begin
      if (cmd.accept && block_end) begin
         hold_ff       <= run_total;
         addr_ff       <= col_ff;
         first_line_ff <= (ysub_ff == '0);
         emit_ff       <= line_last;
         last_col_ff   <= last_col;
         last_row_ff   <= last_row;
         rd_ff         <= col_mem[col_ff];
      end
   end

   // The first line of a block row starts a fresh column sum, so the store
   // never needs clearing
   assign total = (first_line_ff ? '0 : rd_ff) + SUM_W'(hold_ff);

   always_ff @(posedge clock) begin
      if (cmd.col_write) begin
         col_mem[addr_ff] <= total;
      end
   end

   // Average: sum * k / (fx * fy)
   assign area     = fx_ff * fy_ff;
   assign dividend = byte_mode_ff ? {total, 2'b00} : {2'b00, total};

   boxds_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (area[DIVISOR_W-1:0]),
      .done     (div_done),
      .quotient (quotient)
   );

   // Output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_pixel_ff     <= quotient;
         out_row_end_ff   <= last_col_ff;
         out_slice_end_ff <= last_col_ff && last_row_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel_out = out_pixel_ff;
   assign rsp_row_end   = out_row_end_ff;
   assign rsp_slice_end = out_slice_end_ff;

   // Status to the controller
   always_comb begin
      status.block_end = block_end;
      status.emit      = emit_ff;
      status.div_done  = div_done;
      status.slot_free = !out_valid_ff || !rsp_stall;
   end

endmodule

FILE: rtl/boxds_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences accept, column update, divide and output load.
// Depends on boxds_pkg.
module boxds_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  boxds_pkg::dp_status_type   status,
   output boxds_pkg::dp_cmd_type      cmd
);
   import boxds_pkg::*;

   ctrl_state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.block_end) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            state_in = status.emit ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.slot_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_ACC: begin
            cmd.col_write = !status.emit;
            cmd.div_start = status.emit;
         end
         ST_DIV: begin
            cmd = '0;
         end
         ST_OUT: begin
            cmd.load_out = status.slot_free;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/boxds_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the box-average downscaler, bound to the top level.
// Depends on boxds_pkg and box_average_image_downscaler.
module boxds_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [boxds_pkg::PIX_W-1:0]       rsp_pixel_out,
   input  logic                              rsp_row_end,
   input  logic                              rsp_slice_end
);

   // A stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out)
         && $stable(rsp_row_end) && $stable(rsp_slice_end))
      else $error("rsp item changed while stalled");

   // The end of a slice is always the end of an output row
   a_slice_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_slice_end |-> rsp_row_end)
      else $error("slice_end without row_end");

   // Input stall only starts right after an item was taken
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && !req_stall))
      else $error("req_stall rose without an accepted item");

   // A new result is only loaded while the input side is held off
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("rsp_valid rose outside a block computation");

endmodule

bind box_average_image_downscaler boxds_checker u_boxds_checker (.*);

FILE: dv/box_average_image_downscaler_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for box_average_image_downscaler: streams pixel slices,
// predicts every block average with its row/slice flags and checks each output item.
// Depends on boxds_pkg and the downscaler RTL.
module box_average_image_downscaler_tb;
   import boxds_pkg::*;

   localparam int HALF_PERIOD     = 4;
   localparam int RESET_CYCLES    = 6;
   localparam int SETTLE_CYCLES   = 48;
   localparam int SQUEEZE_CYCLES  = 300;
   localparam int QUIET_PERIOD    = 3000;
   localparam int QUIET_SPAN      = 600;
   localparam int IDLE_PERCENT    = 25;
   localparam int RANDOM_ITEMS    = 480;
   localparam int MAX_REPORTS     = 10;
   localparam int HEIGHT_LIMIT    = (1 << HEIGHT_W) - 1;
   localparam int FACTOR_FIELD_MAX = (1 << FACTOR_W) - 1;
   localparam int WIDTH_FIELD_MAX = (1 << WIDTH_W) - 1;
   localparam int WIDE_ITEMS      = 64;
   localparam int BYTE_SCALE      = 4;
   localparam longint TIMEOUT_NS  = 64'd12_000_000;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LAST  = '1;
   localparam logic [PIX_W-1:0]     PIX_MAX         = '1;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             row_end;
      logic             slice_end;
   } block_avg_t;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } reg_write_t;

   // DUT connections, all inputs known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_pixel_in = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic                  rsp_row_end;
   logic                  rsp_slice_end;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   box_average_image_downscaler dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_row_end   (rsp_row_end),
      .rsp_slice_end (rsp_slice_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // Stimulus and scoreboard storage
   logic [PIX_W-1:0] pending_pixels[$];
   block_avg_t       awaited_pixels[$];
   reg_write_t       reg_writes[$];
   block_avg_t       seen_want;
   int unsigned      error_count = 0;
   int unsigned      cycle_count = 0;
   int unsigned      squeeze_ticks = 0;
   logic             squeeze_armed = 1'b0;
   logic             calm;

   // Predictor copy of the registers and the accumulation state
   logic [FACTOR_W-1:0] scale_x = 1;
   logic [FACTOR_W-1:0] scale_y = 1;
   logic [WIDTH_W-1:0]  span_x = MAX_WIDTH;
   logic [HEIGHT_W-1:0] span_y = MAX_WIDTH;
   logic                byte_input = 1'b0;
   logic [SUM_W-1:0]    column_sum [MAX_WIDTH];
   int unsigned         run_sum, x_at, y_at;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Free-running cycle count; idling is off during one window of each period
   always @(posedge clock) cycle_count <= cycle_count + 1;
   assign calm = (cycle_count % QUIET_PERIOD) < QUIET_SPAN;

   function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   task automatic restart_slice();
      foreach (column_sum[i]) column_sum[i] = '0;
      run_sum = 0;
      x_at = 0;
      y_at = 0;
   endtask

   // Register write as seen by the predictor; spare indexes change nothing
   task automatic apply_register(input reg_write_t wr);
      case (wr.index)
         REG_FACTOR_X:     scale_x = wr.data[FACTOR_W-1:0];
         REG_FACTOR_Y:     scale_y = wr.data[FACTOR_W-1:0];
         REG_IMAGE_WIDTH:  span_x = wr.data[WIDTH_W-1:0];
         REG_IMAGE_HEIGHT: span_y = wr.data[HEIGHT_W-1:0];
         REG_BYTE_MODE:    byte_input = wr.data[0];
         default:          return;
      endcase
      restart_slice();
   endtask

   // Adds one pixel into its block; queues the average when the block completes
   task automatic average_pixel(input logic [PIX_W-1:0] raw);
      int unsigned fx, fy, w, h, cols, rows, col, pix;
      longint unsigned scaled;
      block_avg_t result;
      fx = clamp_to(scale_x, MAX_FACTOR);
      fy = clamp_to(scale_y, MAX_FACTOR);
      w = clamp_to(span_x, MAX_WIDTH);
      h = clamp_to(span_y, HEIGHT_LIMIT);
      cols = w / fx;
      rows = h / fy;
      pix = byte_input ? raw[7:0] : raw;
      if (x_at >= w) x_at = 0;
      if (y_at >= h) y_at = 0;
      // edge columns and rows outside whole blocks are dropped
      if (x_at < cols * fx && y_at < rows * fy) begin
         col = x_at / fx;
         run_sum += pix;
         if ((x_at + 1) % fx == 0) begin
            column_sum[col] = column_sum[col] + SUM_W'(run_sum);
            run_sum = 0;
            if ((y_at + 1) % fy == 0) begin
               scaled = column_sum[col];
               scaled = scaled * (byte_input ? BYTE_SCALE : 1) / (fx * fy);
               result.pixel = scaled[PIX_W-1:0];
               result.row_end = (col + 1 == cols);
               result.slice_end = (col + 1 == cols) && (y_at / fy + 1 == rows);
               column_sum[col] = '0;
               awaited_pixels.push_back(result);
            end
         end
      end
      x_at++;
      if (x_at >= w) begin
         x_at = 0;
         run_sum = 0;
         y_at++;
         if (y_at >= h) y_at = 0;
      end
   endtask

   // Pixel driver: predicts on each accepted item, holds payload while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) average_pixel(req_pixel_in);
         if (!req_valid || !req_stall) begin
            if (pending_pixels.size() != 0 &&
                (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
               req_valid <= 1'b1;
               req_pixel_in <= pending_pixels.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Output back-pressure: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (squeeze_armed && squeeze_ticks < SQUEEZE_CYCLES) begin
         rsp_stall <= 1'b1;
         squeeze_ticks <= squeeze_ticks + 1;
      end else begin
         rsp_stall <= !reset && !calm && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   // Output monitor: compare each accepted item with the oldest expected average
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_pixels.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("ERROR: unexpected output pixel=%h row_end=%b slice_end=%b",
                        rsp_pixel_out, rsp_row_end, rsp_slice_end);
         end else begin
            seen_want = awaited_pixels.pop_front();
            if (rsp_pixel_out !== seen_want.pixel || rsp_row_end !== seen_want.row_end ||
                rsp_slice_end !== seen_want.slice_end) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("ERROR: pixel exp %h got %h, row_end exp %b got %b, %s",
                           seen_want.pixel, rsp_pixel_out, seen_want.row_end, rsp_row_end,
                           $sformatf("slice_end exp %b got %b",
                                     seen_want.slice_end, rsp_slice_end));
            end
         end
      end
   end

   // Wait for the pipe to empty, then let a pixel without output finish
   task automatic wait_drained();
      while (pending_pixels.size() != 0 || req_valid || awaited_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_registers();
      reg_write_t wr;
      while (reg_writes.size() != 0) begin
         wr = reg_writes.pop_front();
         csr_valid <= 1'b1;
         csr_index <= wr.index;
         csr_wdata <= wr.data;
         do @(posedge clock); while (!csr_ready);
         apply_register(wr);
      end
      csr_valid <= 1'b0;
   endtask

   // Junk above the used bits of a narrow register must be ignored
   function automatic logic [CSR_DATA_W-1:0] add_spare_bits(int unsigned value,
                                                             int unsigned bits);
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom_range(1) ? CSR_DATA_W'($urandom() << bits) : '0;
      return junk | CSR_DATA_W'(value);
   endfunction

   function automatic int unsigned pick_factor();
      case ($urandom_range(9))
         0:       return 0;
         1:       return MAX_FACTOR;
         2:       return $urandom_range(MAX_FACTOR + 1, FACTOR_FIELD_MAX);
         3:       return $urandom_range(1, MAX_FACTOR);
         default: return $urandom_range(1, 4);
      endcase
   endfunction

   function automatic int unsigned pick_span(int unsigned f, int unsigned reach);
      case ($urandom_range(19))
         0:       return 0;
         1, 2:    return $urandom_range(1, 2 * f);
         default: return f * $urandom_range(1, reach) +
                         ($urandom_range(1) ? $urandom_range(0, f - 1) : 0);
      endcase
   endfunction

   // One random setting followed by whole slices, or now and then a broken count
   task automatic random_phase(output int unsigned items);
      int unsigned fx_val, fy_val, fx, fy, frame, pattern;
      fx_val = pick_factor();
      fy_val = pick_factor();
      fx = clamp_to(fx_val, MAX_FACTOR);
      fy = clamp_to(fy_val, MAX_FACTOR);
      if ($urandom_range(7) == 0)
         reg_writes.push_back('{CSR_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                                CSR_DATA_W'($urandom())});
      if ($urandom_range(4) != 0)
         reg_writes.push_back('{REG_FACTOR_X, add_spare_bits(fx_val, FACTOR_W)});
      if ($urandom_range(4) != 0)
         reg_writes.push_back('{REG_FACTOR_Y, add_spare_bits(fy_val, FACTOR_W)});
      if ($urandom_range(4) != 0)
         reg_writes.push_back('{REG_IMAGE_WIDTH,
                                CSR_DATA_W'(pick_span(fx, fx > 4 ? 2 : 5))});
      if ($urandom_range(4) != 0)
         reg_writes.push_back('{REG_IMAGE_HEIGHT,
                                CSR_DATA_W'(pick_span(fy, fy > 4 ? 1 : 3))});
      if ($urandom_range(4) != 0)
         reg_writes.push_back('{REG_BYTE_MODE, add_spare_bits($urandom_range(1), 1)});
      program_registers();

      frame = clamp_to(span_x, MAX_WIDTH) * clamp_to(span_y, HEIGHT_LIMIT);
      if (frame <= 256 && $urandom_range(9) < 8) items = frame * $urandom_range(1, 2);
      else items = $urandom_range(1, 160);
      pattern = $urandom_range(7);
      repeat (items) begin
         case (pattern)
            0:       pending_pixels.push_back(PIX_MAX);
            1:       pending_pixels.push_back($urandom_range(1) ? PIX_MAX : '0);
            default: pending_pixels.push_back(PIX_W'($urandom()));
         endcase
      end
   endtask

   // Phase sequencer
   initial begin
      int unsigned random_count, phase_items;
      restart_slice();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // settings after reset: 16-bit pass-through
      pending_pixels.push_back('0);
      pending_pixels.push_back(PIX_MAX);
      pending_pixels.push_back(16'h8000);
      pending_pixels.push_back(16'h7FFF);
      wait_drained();

      // 2x2 blocks on a 5x3 image: last column and last row dropped, max sums
      reg_writes.push_back('{REG_FACTOR_X, 2});
      reg_writes.push_back('{REG_FACTOR_Y, 2});
      reg_writes.push_back('{REG_IMAGE_WIDTH, 5});
      reg_writes.push_back('{REG_IMAGE_HEIGHT, 3});
      reg_writes.push_back('{REG_BYTE_MODE, 0});
      program_registers();
      for (int i = 0; i < 15; i++)
         pending_pixels.push_back(i < 10 ? PIX_MAX : PIX_W'($urandom()));
      wait_drained();

      // byte mode with zero factors; a spare-index write must not restart the slice
      reg_writes.push_back('{REG_FACTOR_X, 0});
      reg_writes.push_back('{REG_FACTOR_Y, 0});
      reg_writes.push_back('{REG_IMAGE_WIDTH, 3});
      reg_writes.push_back('{REG_IMAGE_HEIGHT, 2});
      reg_writes.push_back('{REG_BYTE_MODE, 1});
      program_registers();
      pending_pixels.push_back(PIX_MAX);
      pending_pixels.push_back(16'h12AB);
      pending_pixels.push_back(16'hFF00);
      wait_drained();
      reg_writes.push_back('{REG_SPARE_FIRST, 1});
      reg_writes.push_back('{REG_SPARE_LAST, WIDTH_FIELD_MAX});
      program_registers();
      pending_pixels.push_back(16'h00FF);
      pending_pixels.push_back(16'h0001);
      pending_pixels.push_back(16'h8080);
      wait_drained();

      // oversize factors on a zero-sized image: block larger than image, no output
      reg_writes.push_back('{REG_FACTOR_X, FACTOR_FIELD_MAX});
      reg_writes.push_back('{REG_FACTOR_Y, MAX_FACTOR + 4});
      reg_writes.push_back('{REG_IMAGE_WIDTH, 0});
      reg_writes.push_back('{REG_IMAGE_HEIGHT, 0});
      program_registers();
      pending_pixels.push_back(PIX_W'($urandom()));
      pending_pixels.push_back(PIX_W'($urandom()));
      wait_drained();

      // output held off for a long stretch while pixels keep coming
      reg_writes.push_back('{REG_FACTOR_X, 1});
      reg_writes.push_back('{REG_FACTOR_Y, 1});
      reg_writes.push_back('{REG_IMAGE_WIDTH, 8});
      reg_writes.push_back('{REG_IMAGE_HEIGHT, 8});
      reg_writes.push_back('{REG_BYTE_MODE, 0});
      program_registers();
      squeeze_armed <= 1'b1;
      repeat (64) pending_pixels.push_back(PIX_W'($urandom()));
      random_count = 64;

      // random settings and slices
      while (random_count < RANDOM_ITEMS) begin
         wait_drained();
         random_phase(phase_items);
         random_count += phase_items;
      end
      wait_drained();

      // width above the line store is held at the store size
      reg_writes.push_back('{REG_FACTOR_X, MAX_FACTOR});
      reg_writes.push_back('{REG_FACTOR_Y, 1});
      reg_writes.push_back('{REG_IMAGE_WIDTH,
                             CSR_DATA_W'($urandom_range(MAX_WIDTH + 1, WIDTH_FIELD_MAX))});
      reg_writes.push_back('{REG_IMAGE_HEIGHT, 1});
      reg_writes.push_back('{REG_BYTE_MODE, CSR_DATA_W'($urandom_range(1))});
      program_registers();
      repeat (WIDE_ITEMS) pending_pixels.push_back(PIX_W'($urandom()));
      wait_drained();

      if (error_count == 0 && awaited_pixels.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Hang guard
   initial begin
      #(TIMEOUT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
